### sv/xae_pkg.sv
// shared types, constants and helper functions for the alu encoder
package xae_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [2:0] TAG_END  = 3'd0;
    localparam logic [2:0] TAG_REG  = 3'd1;
    localparam logic [2:0] TAG_IMM  = 3'd2;
    localparam logic [2:0] TAG_MEM  = 3'd5;
    localparam logic [2:0] TAG_DISP = 3'd6;
    localparam logic [2:0] TAG_LBL  = 3'd7;

    localparam logic [7:0] PREFIX_BYTE = 8'h66;

    localparam logic [3:0] ERR_REG  = 4'b0001;
    localparam logic [3:0] ERR_IMM  = 4'b0010;
    localparam logic [3:0] ERR_PAIR = 4'b0100;
    localparam logic [3:0] ERR_FORM = 4'b1000;

    // one classified instruction: up to five bytes and shared flags
    typedef struct packed {
        logic [4:0][7:0] bytes;
        logic [2:0]      count;
        logic [3:0]      flags;
        logic            no_form;
    } t_enc;

    function automatic logic tags_are(input logic [4:0][2:0] t, input logic [2:0] a,
                                      input logic [2:0] b, input logic [2:0] c,
                                      input logic [2:0] d);
        logic [4:0][2:0] p;
        logic            res;
        logic            done;
        p = {TAG_END, d, c, b, a};
        res = 1'b1;
        done = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (!done) begin
                if (t[k] != p[k]) begin
                    res = 1'b0;
                    done = 1'b1;
                end else if (p[k] == TAG_END) begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic logic is16(input logic signed [31:0] v);
        return v[5:4] == 2'b01;
    endfunction

    function automatic logic short_disp(input logic signed [31:0] v);
        return v >= 0 && v < 256;
    endfunction

    function automatic logic bad_r8(input logic signed [31:0] v);
        return v < 0 || v > 15;
    endfunction

    function automatic logic bad_r16(input logic signed [31:0] v);
        return v < 16 || v > 31;
    endfunction

    function automatic logic bad_k8(input logic signed [31:0] v);
        return v < -128 || v > 255;
    endfunction

    function automatic logic bad_k16(input logic signed [31:0] v);
        return v < -32768 || v > 65535;
    endfunction

    // base/index pair to r/m; bit 3 of the result flags a bad pair
    function automatic logic [3:0] base_index(input logic [2:0] b, input logic [2:0] i,
                                              input logic has_i);
        logic [3:0] r;
        r = 4'b1000;
        if (has_i) begin
            if (b == 3'd3 && i == 3'd6) r = 4'd0;
            else if (b == 3'd3 && i == 3'd7) r = 4'd1;
            else if (b == 3'd5 && i == 3'd6) r = 4'd2;
            else if (b == 3'd5 && i == 3'd7) r = 4'd3;
        end else begin
            if (b == 3'd6) r = 4'd4;
            else if (b == 3'd7) r = 4'd5;
            else if (b == 3'd5) r = 4'd6;
            else if (b == 3'd3) r = 4'd7;
        end
        return r;
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rm,
                                         input logic [2:0] rg);
        return {md, rg, rm};
    endfunction

endpackage

### sv/x86_alu_instruction_encoder_core.sv
// top level of the 16-bit alu instruction encoder
// Encodes one ALU instruction (add, or, adc, sbb, and, sub, xor, cmp) per request
// into one to five result bytes, one result per cycle while i_ready is high, with
// o_last on the final one. A request gives one result per byte (1 to 5), counted
// out by the back end's byte sender. The front end classifies the next request and a
// two-entry queue holds classified requests, so input is taken while bytes stream.
// A no-match request gives one result with o_has_byte low and error bit 3 set.
module x86_alu_instruction_encoder_core import xae_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [2:0]         i_tag_0,
    input  logic [2:0]         i_tag_1,
    input  logic [2:0]         i_tag_2,
    input  logic [2:0]         i_tag_3,
    input  logic [2:0]         i_tag_4,
    input  logic signed [31:0] i_value_0,
    input  logic signed [31:0] i_value_1,
    input  logic signed [31:0] i_value_2,
    input  logic signed [31:0] i_value_3,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_has_byte,
    output logic               o_last,
    output logic [3:0]         o_error_flags
);
    logic f_valid;
    logic f_ready;
    t_enc f_enc;
    logic q_valid;
    logic q_ready;
    t_enc q_enc;

    xae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_command (i_command),
        .i_tags  ({i_tag_4, i_tag_3, i_tag_2, i_tag_1, i_tag_0}),
        .i_v0    (i_value_0),
        .i_v1    (i_value_1),
        .i_v2    (i_value_2),
        .i_v3    (i_value_3),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_enc   (f_enc)
    );

    xae_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_enc   (f_enc),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_enc   (q_enc)
    );

    xae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_enc         (q_enc),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_last        (o_last),
        .o_error_flags (o_error_flags)
    );
endmodule

### sv/xae_front.sv
// front end: accepts instructions, matches operand forms, builds the byte list
module xae_front import xae_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [4:0][2:0]    i_tags,
    input  logic signed [31:0] i_v0,
    input  logic signed [31:0] i_v1,
    input  logic signed [31:0] i_v2,
    input  logic signed [31:0] i_v3,
    output logic               o_valid,
    input  logic               i_ready,
    output t_enc               o_enc
);
    logic       r_valid;
    t_enc       r_enc;
    t_enc       n_enc;
    logic [7:0] op;
    logic [3:0] bi;
    logic [3:0] fl;

    always_comb begin
        op = {2'b00, i_command, 3'b000};
        n_enc = '0;
        fl = '0;
        bi = '0;
        // forms in priority order
        if (tags_are(i_tags, TAG_REG, TAG_REG, TAG_END, TAG_END) && i_v0[5:4] == 2'b00) begin
            fl[0] = bad_r8(i_v1);
            n_enc.bytes[0] = op;
            n_enc.bytes[1] = modrm(2'd3, i_v0[2:0], i_v1[2:0]);
            n_enc.count = 3'd2;
        end else if (tags_are(i_tags, TAG_REG, TAG_IMM, TAG_END, TAG_END) && i_v0 == 0) begin
            fl[1] = bad_k8(i_v1);
            n_enc.bytes[0] = op + 8'd4;
            n_enc.bytes[1] = i_v1[7:0];
            n_enc.count = 3'd2;
        end else if (tags_are(i_tags, TAG_MEM, TAG_REG, TAG_END, TAG_END) && is16(i_v0)) begin
            bi = base_index(i_v0[2:0], 3'd0, 1'b0);
            fl[0] = bad_r16(i_v1);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd0, bi[2:0], i_v1[2:0]);
            n_enc.count = 3'd2;
        end else if (tags_are(i_tags, TAG_MEM, TAG_MEM, TAG_REG, TAG_END) && is16(i_v0)) begin
            bi = base_index(i_v0[2:0], i_v1[2:0], 1'b1);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd0, bi[2:0], i_v2[2:0]);
            n_enc.count = 3'd2;
        end else if ((tags_are(i_tags, TAG_DISP, TAG_REG, TAG_END, TAG_END)
                      || tags_are(i_tags, TAG_LBL, TAG_REG, TAG_END, TAG_END)) && is16(i_v1)) begin
            fl[1] = bad_k16(i_v0);
            n_enc.bytes[0] = PREFIX_BYTE;
            n_enc.bytes[1] = op + 8'd1;
            n_enc.bytes[2] = modrm(2'd0, 3'd6, i_v1[2:0]);
            n_enc.bytes[3] = (i_tags[0] == TAG_DISP) ? i_v0[7:0] : 8'd0;
            n_enc.bytes[4] = (i_tags[0] == TAG_DISP) ? i_v0[15:8] : 8'd0;
            n_enc.count = 3'd5;
        end else if (tags_are(i_tags, TAG_MEM, TAG_DISP, TAG_REG, TAG_END) && is16(i_v0)
                     && short_disp(i_v1)) begin
            bi = base_index(i_v0[2:0], 3'd0, 1'b0);
            fl[0] = bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd1, bi[2:0], i_v2[2:0]);
            n_enc.bytes[2] = i_v1[7:0];
            n_enc.count = 3'd3;
        end else if (tags_are(i_tags, TAG_MEM, TAG_MEM, TAG_DISP, TAG_REG) && is16(i_v0)
                     && short_disp(i_v2)) begin
            bi = base_index(i_v0[2:0], i_v1[2:0], 1'b1);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v3);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd1, bi[2:0], i_v3[2:0]);
            n_enc.bytes[2] = i_v2[7:0];
            n_enc.count = 3'd3;
        end else if ((tags_are(i_tags, TAG_MEM, TAG_DISP, TAG_REG, TAG_END)
                      || tags_are(i_tags, TAG_MEM, TAG_LBL, TAG_REG, TAG_END)) && is16(i_v0)) begin
            bi = base_index(i_v0[2:0], 3'd0, 1'b0);
            fl[1] = bad_k16(i_v1);
            fl[0] = bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd2, bi[2:0], i_v2[2:0]);
            n_enc.bytes[2] = (i_tags[1] == TAG_DISP) ? i_v1[7:0] : 8'd0;
            n_enc.bytes[3] = (i_tags[1] == TAG_DISP) ? i_v1[15:8] : 8'd0;
            n_enc.count = 3'd4;
        end else if ((tags_are(i_tags, TAG_MEM, TAG_MEM, TAG_DISP, TAG_REG)
                      || tags_are(i_tags, TAG_MEM, TAG_MEM, TAG_LBL, TAG_REG)) && is16(i_v0)) begin
            bi = base_index(i_v0[2:0], i_v1[2:0], 1'b1);
            fl[1] = bad_k16(i_v2);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v3);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd2, bi[2:0], i_v3[2:0]);
            n_enc.bytes[2] = (i_tags[2] == TAG_DISP) ? i_v2[7:0] : 8'd0;
            n_enc.bytes[3] = (i_tags[2] == TAG_DISP) ? i_v2[15:8] : 8'd0;
            n_enc.count = 3'd4;
        end else if (tags_are(i_tags, TAG_REG, TAG_REG, TAG_END, TAG_END) && is16(i_v0)) begin
            fl[0] = bad_r16(i_v1);
            n_enc.bytes[0] = op + 8'd1;
            n_enc.bytes[1] = modrm(2'd3, i_v0[2:0], i_v1[2:0]);
            n_enc.count = 3'd2;
        end else if (tags_are(i_tags, TAG_REG, TAG_MEM, TAG_END, TAG_END) && is16(i_v0)) begin
            bi = base_index(i_v1[2:0], 3'd0, 1'b0);
            fl[0] = bad_r16(i_v1);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd0, bi[2:0], i_v0[2:0]);
            n_enc.count = 3'd2;
        end else if (tags_are(i_tags, TAG_REG, TAG_MEM, TAG_MEM, TAG_END) && is16(i_v0)) begin
            bi = base_index(i_v1[2:0], i_v2[2:0], 1'b1);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd0, bi[2:0], i_v0[2:0]);
            n_enc.count = 3'd2;
        end else if ((tags_are(i_tags, TAG_REG, TAG_DISP, TAG_END, TAG_END)
                      || tags_are(i_tags, TAG_REG, TAG_LBL, TAG_END, TAG_END)) && is16(i_v0)) begin
            fl[1] = bad_k16(i_v1);
            n_enc.bytes[0] = PREFIX_BYTE;
            n_enc.bytes[1] = op + 8'd3;
            n_enc.bytes[2] = modrm(2'd0, 3'd6, i_v0[2:0]);
            n_enc.bytes[3] = (i_tags[1] == TAG_DISP) ? i_v1[7:0] : 8'd0;
            n_enc.bytes[4] = (i_tags[1] == TAG_DISP) ? i_v1[15:8] : 8'd0;
            n_enc.count = 3'd5;
        end else if (tags_are(i_tags, TAG_REG, TAG_MEM, TAG_DISP, TAG_END) && is16(i_v0)
                     && short_disp(i_v2)) begin
            bi = base_index(i_v1[2:0], 3'd0, 1'b0);
            fl[0] = bad_r16(i_v1);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd1, bi[2:0], i_v0[2:0]);
            n_enc.bytes[2] = i_v2[7:0];
            n_enc.count = 3'd3;
        end else if (tags_are(i_tags, TAG_REG, TAG_MEM, TAG_MEM, TAG_DISP) && is16(i_v0)
                     && short_disp(i_v3)) begin
            bi = base_index(i_v1[2:0], i_v2[2:0], 1'b1);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd1, bi[2:0], i_v0[2:0]);
            n_enc.bytes[2] = i_v3[7:0];
            n_enc.count = 3'd3;
        end else if ((tags_are(i_tags, TAG_REG, TAG_MEM, TAG_DISP, TAG_END)
                      || tags_are(i_tags, TAG_REG, TAG_MEM, TAG_LBL, TAG_END)) && is16(i_v0)) begin
            bi = base_index(i_v1[2:0], 3'd0, 1'b0);
            fl[1] = bad_k16(i_v2);
            fl[0] = bad_r16(i_v1);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd2, bi[2:0], i_v0[2:0]);
            n_enc.bytes[2] = (i_tags[2] == TAG_DISP) ? i_v2[7:0] : 8'd0;
            n_enc.bytes[3] = (i_tags[2] == TAG_DISP) ? i_v2[15:8] : 8'd0;
            n_enc.count = 3'd4;
        end else if ((tags_are(i_tags, TAG_REG, TAG_MEM, TAG_MEM, TAG_DISP)
                      || tags_are(i_tags, TAG_REG, TAG_MEM, TAG_MEM, TAG_LBL)) && is16(i_v0)) begin
            bi = base_index(i_v1[2:0], i_v2[2:0], 1'b1);
            fl[1] = bad_k16(i_v3);
            fl[0] = bad_r16(i_v1) | bad_r16(i_v2);
            n_enc.bytes[0] = op + 8'd3;
            n_enc.bytes[1] = modrm(2'd2, bi[2:0], i_v0[2:0]);
            n_enc.bytes[2] = (i_tags[3] == TAG_DISP) ? i_v3[7:0] : 8'd0;
            n_enc.bytes[3] = (i_tags[3] == TAG_DISP) ? i_v3[15:8] : 8'd0;
            n_enc.count = 3'd4;
        end else if (tags_are(i_tags, TAG_REG, TAG_IMM, TAG_END, TAG_END) && i_v0 == 16) begin
            fl[1] = bad_k16(i_v1);
            n_enc.bytes[0] = op + 8'd5;
            n_enc.bytes[1] = i_v1[7:0];
            n_enc.bytes[2] = i_v1[15:8];
            n_enc.count = 3'd3;
        end else begin
            n_enc.no_form = 1'b1;
            n_enc.count = 3'd1;
        end
        // a bad base/index pair gives r/m 0 and a flag
        if (bi[3]) begin
            fl = fl | ERR_PAIR;
        end
        if (n_enc.no_form) begin
            fl = ERR_FORM;
        end
        n_enc.flags = fl;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_enc   = r_enc;

    // classified request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_enc <= n_enc;
        end
    end
endmodule

### sv/xae_queue.sv
// short queue of classified requests between front and back ends
module xae_queue import xae_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_enc i_enc,
    output logic o_valid,
    input  logic i_ready,
    output t_enc o_enc
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_enc          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_ready = r_cnt != DEPTH[AW:0];
    assign o_valid = r_cnt != '0;
    assign o_enc   = r_mem[r_rd];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_enc;
        end
    end
endmodule

### sv/xae_back.sv
// back end: sends the bytes of one classified request, one result per cycle while i_ready is high
module xae_back import xae_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_enc       i_enc,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_last,
    output logic [3:0] o_error_flags
);
    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_last;
    logic [3:0] r_flags;
    logic       load;
    logic       fin;

    // output register free when empty or being taken
    assign load    = !r_valid || i_ready;
    assign fin     = (r_idx + 3'd1) == i_enc.count;
    assign o_ready = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_idx <= fin ? 3'd0 : r_idx + 3'd1;
            end
        end
        if (load && i_valid) begin
            r_byte  <= i_enc.no_form ? 8'd0 : i_enc.bytes[r_idx];
            r_has   <= !i_enc.no_form;
            r_last  <= fin;
            r_flags <= i_enc.flags;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_has_byte    = r_has;
    assign o_last        = r_last;
    assign o_error_flags = r_flags;
endmodule
